FILE: design/mcspg_pkg.sv
// ----------------------------------------------------------------------------
// mcspg_pkg: shared types for the multi-channel step pulse generator
// Request, result and configuration payloads, channel control and status
// bundles, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package mcspg_pkg;

    localparam int COUNT_W  = 16;  // prescale, reload and edge count width
    localparam int OUT_CH   = 4;   // channels visible in result fields
    localparam int REG_CH   = 4;   // channels with a reload register
    localparam int CHAN_W   = 2;
    localparam int CFG_IDX_W = 3;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_LOAD = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RELOAD_CH0  = 3'd0,
        REG_RELOAD_CH1  = 3'd1,
        REG_RELOAD_CH2  = 3'd2,
        REG_RELOAD_CH3  = 3'd3,
        REG_CONT_MASK   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        kind_t               kind;
        logic [CHAN_W-1:0]   channel;
        logic [COUNT_W-1:0]  edge_count;
    } req_t;

    typedef struct packed {
        logic [OUT_CH-1:0] pin_levels;
        logic [OUT_CH-1:0] toggled;
        logic [OUT_CH-1:0] busy_res;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [COUNT_W-1:0]   data;
    } cfg_t;

    // per-channel strobes for one request
    typedef struct packed {
        logic tick;
        logic load;
        logic cont;
    } chan_ctrl_t;

    // per-channel status: current pin and values after the request
    typedef struct packed {
        logic pin_cur;
        logic pin_next;
        logic toggled;
        logic busy_next;
    } chan_stat_t;

endpackage

FILE: design/mcspg_stream_if.sv
// ----------------------------------------------------------------------------
// mcspg_stream_if: valid/ready channel
// Carries one payload of the given type from a source to a sink.
// ----------------------------------------------------------------------------
interface mcspg_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

FILE: design/mcspg_chan.sv
// ----------------------------------------------------------------------------
// mcspg_chan: one step channel
// Prescale down-counter, remaining edge count and step pin level.
// ----------------------------------------------------------------------------
module mcspg_chan
    import mcspg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  chan_ctrl_t         ctrl,
    input  logic [COUNT_W-1:0] reload,
    input  logic [COUNT_W-1:0] edge_count,
    output chan_stat_t         stat
);

    logic [COUNT_W-1:0] prescale_reg;
    logic [COUNT_W-1:0] prescale_next;
    logic [COUNT_W-1:0] edges_reg;
    logic [COUNT_W-1:0] edges_next;
    logic               pin_reg;
    logic               pin_next;
    logic               fire;
    logic               active;

    always_comb
    begin
        active        = ctrl.cont || (edges_reg != '0);
        fire          = 1'b0;
        prescale_next = prescale_reg;
        edges_next    = edges_reg;
        pin_next      = pin_reg;
        if (ctrl.load)
        begin
            edges_next = edge_count;
        end
        else if (ctrl.tick && active)
        begin
            if (prescale_reg == '0)
            begin
                fire          = 1'b1;
                pin_next      = ~pin_reg;
                prescale_next = reload;
                // counted mode spends one edge per toggle
                if (!ctrl.cont)
                begin
                    edges_next = edges_reg - COUNT_W'(1);
                end
            end
            else
            begin
                prescale_next = prescale_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            edges_reg    <= '0;
            pin_reg      <= 1'b0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            edges_reg    <= edges_next;
            pin_reg      <= pin_next;
        end
    end

    assign stat.pin_cur   = pin_reg;
    assign stat.pin_next  = pin_next;
    assign stat.toggled   = fire;
    assign stat.busy_next = (edges_next != '0);

endmodule

FILE: design/multi_channel_step_pulse_generator.sv
// A request's result becomes valid after it passes the request register,
// then the result register; a stalled result sink can hold it between them.
// One request is taken per cycle while the result sink keeps up; the channel
// counters update in parallel, and the result register frees itself when taken.
// Reset: counters, edge counts, pins, reload registers and mask clear to zero.
// ----------------------------------------------------------------------------
// multi_channel_step_pulse_generator: stepper step pin driver
// Ticks advance per-channel prescalers and toggle step pins; load requests
// set a channel's remaining edge count.
// ----------------------------------------------------------------------------
module multi_channel_step_pulse_generator
    import mcspg_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    mcspg_stream_if.sink   req,
    mcspg_stream_if.sink   cfg,
    mcspg_stream_if.source rsp
);

    logic [COUNT_W-1:0] reload_reg [REG_CH];
    logic [REG_CH-1:0]  cont_mask_reg;

    logic               stg_valid_reg;
    req_t               stg_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic               advance;
    logic               do_item;

    chan_ctrl_t         ctrl  [CHANNELS];
    chan_stat_t         stat  [CHANNELS];
    logic [CHANNELS-1:0] pin_cur_vec;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < REG_CH; r++)
            begin
                reload_reg[r] <= '0;
            end
            cont_mask_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_RELOAD_CH0: reload_reg[0] <= cfg.payload.data;
                REG_RELOAD_CH1: reload_reg[1] <= cfg.payload.data;
                REG_RELOAD_CH2: reload_reg[2] <= cfg.payload.data;
                REG_RELOAD_CH3: reload_reg[3] <= cfg.payload.data;
                REG_CONT_MASK:  cont_mask_reg <= cfg.payload.data[REG_CH-1:0];
                default:        ;
            endcase
        end
    end

    // request register feeds the channels; result register holds the answer
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !stg_valid_reg || advance;
    assign do_item   = stg_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                stg_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= stg_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            stg_reg <= req.payload;
        end
        if (do_item)
        begin
            rsp_reg <= rsp_next;
        end
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        if (i < REG_CH)
        begin : g_reg
            assign ctrl[i].tick = do_item && (stg_reg.kind == KIND_TICK);
            assign ctrl[i].load = do_item && (stg_reg.kind == KIND_LOAD)
                                  && (stg_reg.channel == CHAN_W'(i));
            assign ctrl[i].cont = cont_mask_reg[i];

            mcspg_chan u_chan (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[i]),
                .reload     (reload_reg[i]),
                .edge_count (stg_reg.edge_count),
                .stat       (stat[i])
            );
        end
        else
        begin : g_noreg
            // no reload register, counted mode, not reachable by a load
            assign ctrl[i].tick = do_item && (stg_reg.kind == KIND_TICK);
            assign ctrl[i].load = 1'b0;
            assign ctrl[i].cont = 1'b0;

            mcspg_chan u_chan (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[i]),
                .reload     ('0),
                .edge_count (stg_reg.edge_count),
                .stat       (stat[i])
            );
        end
        assign pin_cur_vec[i] = stat[i].pin_cur;
    end

    for (genvar b = 0; b < OUT_CH; b++)
    begin : g_out
        if (b < CHANNELS)
        begin : g_live
            assign rsp_next.pin_levels[b] = stat[b].pin_next;
            assign rsp_next.toggled[b]    = stat[b].toggled;
            assign rsp_next.busy_res[b]   = stat[b].busy_next;
        end
        else
        begin : g_none
            assign rsp_next.pin_levels[b] = 1'b0;
            assign rsp_next.toggled[b]    = 1'b0;
            assign rsp_next.busy_res[b]   = 1'b0;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // a load request never toggles a pin
    a_load_no_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        do_item && (stg_reg.kind == KIND_LOAD) |=> rsp_reg.toggled == '0)
        else $error("load request reported a toggle");

    // a held request stays put until the result register frees
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg && !advance |=> stg_valid_reg && $stable(stg_reg))
        else $error("pending request lost or changed");

    // channel 0's reported level differs from its previous pin exactly when toggled
    a_toggle_levels: assert property (@(posedge clk) disable iff (!rst_n)
        do_item |=> rsp_reg.pin_levels[0] ==
                    ($past(pin_cur_vec[0]) ^ rsp_reg.toggled[0]))
        else $error("pin level does not match toggle report");

endmodule

FILE: verif/mcspg_step_checker.sv
// ----------------------------------------------------------------------------
// mcspg_step_checker: result checker for the step pulse generator
// Watches the request, configuration and result channels, keeps its own copy
// of the channel counters, pins and registers, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module mcspg_step_checker
    import mcspg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  logic  req_ready,
    input  req_t  req_data,
    input  logic  cfg_valid,
    input  logic  cfg_ready,
    input  cfg_t  cfg_data,
    input  logic  rsp_valid,
    input  logic  rsp_ready,
    input  rsp_t  rsp_data,
    output int    fail_count,
    output int    pending
);

    logic [COUNT_W-1:0] reload_val [OUT_CH];
    logic [COUNT_W-1:0] prescale   [OUT_CH];
    logic [COUNT_W-1:0] edges_left [OUT_CH];
    logic [OUT_CH-1:0]  cont_mask;
    logic [OUT_CH-1:0]  pins;
    rsp_t               expected_pins_q [$];

    // advance the channel model by one request and return the pin status
    function automatic rsp_t advance_channels(input req_t r);
        rsp_t              res;
        logic [OUT_CH-1:0] flips;
        logic [OUT_CH-1:0] busy;
        flips = '0;
        busy  = '0;
        if (r.kind == KIND_LOAD) begin
            edges_left[r.channel] = r.edge_count;
        end else begin
            for (int i = 0; i < OUT_CH; i++) begin
                // counted channel with no edges left holds its prescaler
                if (cont_mask[i] || edges_left[i] != '0) begin
                    if (prescale[i] == '0) begin
                        pins[i]     = ~pins[i];
                        prescale[i] = reload_val[i];
                        flips[i]    = 1'b1;
                        if (!cont_mask[i])
                            edges_left[i] = edges_left[i] - COUNT_W'(1);
                    end else begin
                        prescale[i] = prescale[i] - COUNT_W'(1);
                    end
                end
            end
        end
        for (int i = 0; i < OUT_CH; i++)
            busy[i] = (edges_left[i] != '0);
        res.pin_levels = pins;
        res.toggled    = flips;
        res.busy_res   = busy;
        return res;
    endfunction

    task automatic check_field(input string label, input logic [OUT_CH-1:0] want,
                               input logic [OUT_CH-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            for (int i = 0; i < OUT_CH; i++) begin
                reload_val[i] = '0;
                prescale[i]   = '0;
                edges_left[i] = '0;
            end
            cont_mask = '0;
            pins      = '0;
            expected_pins_q.delete();
            fail_count = 0;
            pending   <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_data.index))
                    REG_RELOAD_CH0: reload_val[0] = cfg_data.data;
                    REG_RELOAD_CH1: reload_val[1] = cfg_data.data;
                    REG_RELOAD_CH2: reload_val[2] = cfg_data.data;
                    REG_RELOAD_CH3: reload_val[3] = cfg_data.data;
                    REG_CONT_MASK:  cont_mask     = cfg_data.data[OUT_CH-1:0];
                    default: ;  // unmapped index, drop
                endcase
            end
            if (rsp_valid && rsp_ready) begin
                if (expected_pins_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, rsp_data);
                    fail_count++;
                end else begin
                    want = expected_pins_q.pop_front();
                    check_field("pin_levels", want.pin_levels, rsp_data.pin_levels);
                    check_field("toggled", want.toggled, rsp_data.toggled);
                    check_field("busy_res", want.busy_res, rsp_data.busy_res);
                end
            end
            if (req_valid && req_ready)
                expected_pins_q.push_back(advance_channels(req_data));
            pending <= expected_pins_q.size();
        end
    end

endmodule

FILE: verif/tb_multi_channel_step_pulse_generator.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_step_pulse_generator: step pulse generator testbench
// Drives directed and random tick and load requests through several register
// settings with bursty requests and a stalling result sink; the checker
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_multi_channel_step_pulse_generator;
    import mcspg_pkg::*;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int LONG_HOLD       = 300;
    localparam int IDLE_LIMIT      = 5000;
    localparam int DRAIN_CYCLES    = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   hold_requests;
    int   burst_left;
    int   idle_cycles = 0;

    mcspg_stream_if #(.payload_t(req_t)) req_if ();
    mcspg_stream_if #(.payload_t(cfg_t)) cfg_if ();
    mcspg_stream_if #(.payload_t(rsp_t)) rsp_if ();

    multi_channel_step_pulse_generator #(.CHANNELS(4)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .cfg   (cfg_if),
        .rsp   (rsp_if)
    );

    mcspg_step_checker step_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_if.valid),
        .req_ready  (req_if.ready),
        .req_data   (req_if.payload),
        .cfg_valid  (cfg_if.valid),
        .cfg_ready  (cfg_if.ready),
        .cfg_data   (cfg_if.payload),
        .rsp_valid  (rsp_if.valid),
        .rsp_ready  (rsp_if.ready),
        .rsp_data   (rsp_if.payload),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic req_t make_req(input kind_t k, input logic [CHAN_W-1:0] ch,
                                      input logic [COUNT_W-1:0] n);
        req_t r;
        r.kind       = k;
        r.channel    = ch;
        r.edge_count = n;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   roll;
        // tick requests carry junk in the load fields
        r.channel    = CHAN_W'($urandom_range(0, 3));
        r.edge_count = COUNT_W'($urandom_range(0, 65535));
        r.kind       = KIND_TICK;
        if ($urandom_range(0, 99) >= 70) begin
            r.kind = KIND_LOAD;
            roll   = $urandom_range(0, 19);
            if (roll == 0)
                r.edge_count = '0;
            else if (roll == 1)
                r.edge_count = 16'hFFFF;
            else if (roll > 3)
                r.edge_count = COUNT_W'($urandom_range(1, 24));
        end
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_reload();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 16'hFFFF;
        else if (roll == 1)
            return COUNT_W'($urandom_range(0, 65535));
        return COUNT_W'($urandom_range(0, 5));
    endfunction

    function automatic logic [COUNT_W-1:0] rand_word(input int lo, input int hi);
        return COUNT_W'($urandom_range(lo, hi));
    endfunction

    // offer one request, in bursts with random gaps between them
    task automatic send_request(input req_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                gap = 20;
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        burst_left--;
    endtask

    // drop valid and hold until every expected result has come back
    task automatic drain();
        req_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COUNT_W-1:0] value);
        cfg_t c;
        c.index = idx;
        c.data  = value;
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= c;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
    endtask

    task automatic configure(input logic [COUNT_W-1:0] r0, input logic [COUNT_W-1:0] r1,
                             input logic [COUNT_W-1:0] r2, input logic [COUNT_W-1:0] r3,
                             input logic [COUNT_W-1:0] mask_word, input bit add_unmapped);
        drain();
        if (add_unmapped)
            write_reg(REG_UNMAPPED_LO, rand_word(0, 65535));
        write_reg(REG_CONT_MASK, mask_word);
        write_reg(REG_RELOAD_CH0, r0);
        write_reg(REG_RELOAD_CH1, r1);
        write_reg(REG_RELOAD_CH2, r2);
        write_reg(REG_RELOAD_CH3, r3);
        if (add_unmapped)
            write_reg(REG_UNMAPPED_HI, rand_word(0, 65535));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_directed();
        // reset settings: counted mode, reload zero, all channels idle
        send_request(make_req(KIND_TICK, 2'd3, 16'hFFFF));
        send_request(make_req(KIND_LOAD, 2'd0, 16'd1));
        send_request(make_req(KIND_LOAD, 2'd1, 16'd2));
        send_request(make_req(KIND_LOAD, 2'd2, 16'd0));
        send_request(make_req(KIND_LOAD, 2'd3, 16'hFFFF));
        repeat (3) send_request(make_req(KIND_TICK, 2'd0, 16'h0000));
        // channels 1 and 2 continuous, upper mask bits must be dropped
        configure(16'h0000, 16'hFFFF, 16'h0002, 16'h0001, 16'hFFF6, 1'b1);
        send_request(make_req(KIND_LOAD, 2'd1, 16'd3));
        send_request(make_req(KIND_LOAD, 2'd0, 16'd2));
        send_request(make_req(KIND_LOAD, 2'd3, 16'h5555));
        repeat (5) send_request(make_req(KIND_TICK, 2'd1, 16'hAAAA));
        send_request(make_req(KIND_LOAD, 2'd3, 16'd0));
        send_request(make_req(KIND_LOAD, 2'd0, 16'hAAAA));
        repeat (2) send_request(make_req(KIND_TICK, 2'd2, 16'h5555));
    endtask

    initial begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        hold_requests  <= 0;
        burst_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
                1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h000F, 1'b1);
                2: configure(rand_word(0, 3), rand_word(0, 3),
                             rand_word(0, 3), rand_word(0, 3), 16'hFFF0, 1'b0);
                3: configure(rand_word(0, 7), rand_word(0, 7),
                             rand_word(0, 7), rand_word(0, 7), 16'h000F, 1'b0);
                default: configure(pick_reload(), pick_reload(), pick_reload(),
                                   pick_reload(), rand_word(0, 65535),
                                   1'($urandom_range(0, 1)));
            endcase
            // long sink stall while requests keep coming
            if (phase == 2)
                hold_requests <= hold_requests + 1;
            repeat (ITEMS_PER_PHASE) send_request(random_request());
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result sink: stall pattern that changes for each random-length window
    initial begin
        int holds_done;
        int mode;
        int window;
        int beat;
        rsp_if.ready <= 1'b0;
        holds_done = 0;
        mode       = 0;
        window     = 0;
        beat       = 0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_requests) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end else begin
                if (window == 0) begin
                    mode   = $urandom_range(0, 3);
                    window = $urandom_range(16, 64);
                end
                window--;
                beat++;
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
                    2:       rsp_if.ready <= (beat % 3 == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog: end the run if no channel moves for too long
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
